// ----- sv/pdvls_pkg.sv -----
package pdvls_pkg;

    typedef struct packed {
        logic        mode;
        logic        attached;
        logic        sink_ready;
        logic [2:0]  protocol_code;
        logic [4:0]  measured_volt;
        logic        cap_5v;
        logic        cap_9v;
        logic        cap_12v;
        logic        cap_15v;
        logic [12:0] contract_current_ma;
    } in_item_t;

    typedef struct packed {
        logic       finished;
        logic       succeeded;
        logic       set_volt_strobe;
        logic [3:0] volt_request;
        logic       gate_open_strobe;
        logic [9:0] freq_limit;
        logic [9:0] core_volt_limit;
    } out_item_t;

    localparam logic MODE_START = 1'b0;

    localparam logic [1:0] CFG_BOARD_MODEL = 2'd0;
    localparam logic [1:0] CFG_FREQ_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_CORE_VOLT   = 2'd2;

    localparam logic [1:0] BOARD_BASE = 2'd1;
    localparam logic [1:0] BOARD_PRO  = 2'd2;

    // ladder rungs in volts, lowest first
    localparam logic [3:0][3:0] LADDER_VOLTS = {4'd15, 4'd12, 4'd9, 4'd5};

    localparam logic [4:0] VOLT_9  = 5'd9;
    localparam logic [4:0] VOLT_12 = 5'd12;
    localparam logic [4:0] VOLT_15 = 5'd15;

    localparam logic [9:0]  STEP_TIMEOUT   = 10'd200;
    localparam logic [10:0] GLOBAL_TIMEOUT = 11'd500;
    localparam logic [9:0]  TICK_MAX       = 10'd1023;

    localparam logic [12:0] CURR_15V_MIN = 13'd2000;
    localparam logic [12:0] CURR_HIGH    = 13'd3000;
    localparam logic [12:0] CURR_MID     = 13'd2770;
    localparam logic [12:0] CURR_LOW     = 13'd2220;

    localparam logic [9:0] FREQ_PRO_HIGH  = 10'd350;
    localparam logic [9:0] FREQ_BASE_HIGH = 10'd650;
    localparam logic [9:0] FREQ_PRO_MID   = 10'd330;
    localparam logic [9:0] FREQ_BASE_MID  = 10'd600;
    localparam logic [9:0] FREQ_PRO_LOW   = 10'd300;
    localparam logic [9:0] FREQ_BASE_LOW  = 10'd480;
    localparam logic [9:0] FREQ_BASE_OTH  = 10'd400;
    localparam logic [9:0] VCORE_PRO_9V   = 10'd95;
    localparam logic [9:0] VCORE_PRO_OTH  = 10'd93;
    localparam logic [9:0] VCORE_BASE     = 10'd115;

    function automatic logic [9:0] clamp10(input logic [9:0] v, input logic [9:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ----- sv/pd_voltage_ladder_sequencer_unit.sv -----
// Power-delivery sink bring-up sequencer. Every input transfer (start or poll
// tick) yields exactly one result transfer. An item is latched in the input
// register, evaluated against the sequencer state and written to the result
// register; one item is taken per cycle as long as the result register
// drains. in_stall rises only when the result register is full and stalled.
// LADDER_DEPTH (1..8) bounds how many supported voltages the ladder keeps; at
// most four are kept, one per capability bit.
module pd_voltage_ladder_sequencer_unit #(
    parameter int LADDER_DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pdvls_pkg::in_item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pdvls_pkg::out_item_t  out_item,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [9:0]            cfg_data
);

    function automatic logic [3:0] ladder_at(input logic [LADDER_DEPTH-1:0][3:0] l,
                                             input logic [2:0] idx);
        logic [3:0] v;
        v = 4'd0;
        for (int k = 0; k < LADDER_DEPTH; k++)
        begin
            if (idx == 3'(k))
                v = l[k];
        end
        return v;
    endfunction

    // pipeline registers
    logic                 in_valid_reg;
    pdvls_pkg::in_item_t  in_item_reg;
    logic                 out_valid_reg;
    pdvls_pkg::out_item_t out_item_reg;
    logic                 adv;
    logic                 proc;

    // configuration
    logic [1:0] board_reg;

    // sequencer state
    logic                          held_reg,    held_next;
    logic                          running_reg, running_next;
    logic                          link_reg,    link_next;
    logic [2:0]                    proto_reg,   proto_next;
    logic [4:0]                    lv_reg,      lv_next;
    logic [LADDER_DEPTH-1:0][3:0]  ladder_reg,  ladder_next;
    logic [2:0]                    count_reg,   count_next;
    logic [2:0]                    index_reg,   index_next;
    logic [3:0]                    target_reg,  target_next;
    logic                          pend_reg,    pend_next;
    logic                          any_reg,     any_next;
    logic                          caps_reg,    caps_next;
    logic [9:0]                    tick_reg,    tick_next;
    logic [9:0]                    freq_reg,    freq_next;
    logic [9:0]                    vcore_reg,   vcore_next;

    logic [LADDER_DEPTH-1:0][3:0]  bld_ladder;
    logic [2:0]                    bld_count;
    logic [10:0]                   tick_inc;
    logic                          done;
    logic                          skip;
    logic                          start_hit;
    logic                          sv;
    logic [3:0]                    vreq;
    logic                          gate_step;
    logic                          judge_ok;
    logic [9:0]                    judge_freq;
    logic [9:0]                    judge_vcore;
    logic                          succ;
    pdvls_pkg::out_item_t          res;

    assign adv      = !out_valid_reg || !out_stall;
    assign proc     = in_valid_reg && adv;
    assign in_stall = in_valid_reg && !adv;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    pdvls_ladder #(
        .LADDER_DEPTH(LADDER_DEPTH)
    ) u_ladder (
        .caps   ({in_item_reg.cap_15v, in_item_reg.cap_12v,
                  in_item_reg.cap_9v, in_item_reg.cap_5v}),
        .ladder (bld_ladder),
        .count  (bld_count)
    );

    always_comb
    begin
        link_next    = link_reg;
        proto_next   = proto_reg;
        lv_next      = lv_reg;
        ladder_next  = ladder_reg;
        count_next   = count_reg;
        index_next   = index_reg;
        target_next  = target_reg;
        pend_next    = pend_reg;
        any_next     = any_reg;
        caps_next    = caps_reg;
        tick_next    = tick_reg;
        running_next = running_reg;
        tick_inc     = 11'd0;
        done         = 1'b0;
        skip         = 1'b0;
        start_hit    = 1'b0;
        sv           = 1'b0;
        vreq         = 4'd0;
        gate_step    = 1'b0;
        if (in_item_reg.mode == pdvls_pkg::MODE_START)
        begin
            if (held_reg)
            begin
                start_hit = 1'b1;
            end
            else
            begin
                link_next    = 1'b0;
                proto_next   = 3'd0;
                lv_next      = 5'd0;
                ladder_next  = '0;
                count_next   = 3'd0;
                index_next   = 3'd0;
                target_next  = 4'd0;
                pend_next    = 1'b0;
                any_next     = 1'b0;
                caps_next    = 1'b0;
                tick_next    = 10'd0;
                running_next = 1'b1;
            end
        end
        else if (running_reg)
        begin
            if (!link_reg)
            begin
                link_next = in_item_reg.attached && in_item_reg.sink_ready;
            end
            else
            begin
                if (proto_reg == 3'd0)
                    proto_next = in_item_reg.protocol_code;
                lv_next = in_item_reg.measured_volt;
            end
            if (link_next && (proto_next != 3'd0))
            begin
                if (!caps_reg)
                begin
                    count_next  = bld_count;
                    ladder_next = bld_ladder;
                    if (bld_count == 3'd0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        target_next = ladder_at(bld_ladder, index_reg);
                        caps_next   = 1'b1;
                    end
                end
                if (!done && (lv_next == {1'b0, target_next}))
                begin
                    any_next = 1'b1;
                    if ((index_reg + 3'd1) >= count_next)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        index_next  = index_reg + 3'd1;
                        target_next = ladder_at(ladder_next, index_next);
                        tick_next   = 10'd0;
                        pend_next   = 1'b0;
                        gate_step   = 1'b1;
                        skip        = 1'b1;
                    end
                end
                if (!done && !skip)
                begin
                    if ((lv_next != 5'd0) && !pend_reg && (target_next != 4'd0))
                    begin
                        sv        = 1'b1;
                        vreq      = target_next;
                        pend_next = 1'b1;
                        tick_next = 10'd0;
                    end
                    if (tick_next > pdvls_pkg::STEP_TIMEOUT)
                    begin
                        index_next = index_reg + 3'd1;
                        if (index_next >= count_next)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            target_next = ladder_at(ladder_next, index_next);
                            pend_next   = 1'b0;
                            tick_next   = 10'd0;
                        end
                    end
                end
            end
            if (!done && !skip)
            begin
                tick_inc  = {1'b0, tick_next} + 11'd1;
                tick_next = (tick_inc > {1'b0, pdvls_pkg::TICK_MAX}) ?
                            pdvls_pkg::TICK_MAX : tick_inc[9:0];
                if (tick_inc > pdvls_pkg::GLOBAL_TIMEOUT)
                    done = 1'b1;
            end
            if (done)
                running_next = 1'b0;
        end
    end

    pdvls_judge u_judge (
        .board     (board_reg),
        .any_ok    (any_next),
        .volt      (lv_next),
        .curr      (in_item_reg.contract_current_ma),
        .freq_in   (freq_reg),
        .vcore_in  (vcore_reg),
        .ok        (judge_ok),
        .freq_out  (judge_freq),
        .vcore_out (judge_vcore)
    );

    always_comb
    begin
        succ       = done && judge_ok;
        held_next  = held_reg || succ;
        freq_next  = done ? judge_freq : freq_reg;
        vcore_next = done ? judge_vcore : vcore_reg;
        res.finished         = start_hit || done;
        res.succeeded        = start_hit || succ;
        res.set_volt_strobe  = sv;
        res.volt_request     = vreq;
        res.gate_open_strobe = gate_step || succ;
        res.freq_limit       = freq_next;
        res.core_volt_limit  = vcore_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
        if (proc)
            out_item_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg <= 2'd0;
            freq_reg  <= 10'd0;
            vcore_reg <= 10'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pdvls_pkg::CFG_BOARD_MODEL: board_reg <= cfg_data[1:0];
                pdvls_pkg::CFG_FREQ_LIMIT:  freq_reg  <= cfg_data;
                pdvls_pkg::CFG_CORE_VOLT:   vcore_reg <= cfg_data;
                default: ;
            endcase
        end
        else if (proc)
        begin
            freq_reg  <= freq_next;
            vcore_reg <= vcore_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= 1'b0;
            running_reg <= 1'b0;
            link_reg    <= 1'b0;
            proto_reg   <= 3'd0;
            lv_reg      <= 5'd0;
            ladder_reg  <= '0;
            count_reg   <= 3'd0;
            index_reg   <= 3'd0;
            target_reg  <= 4'd0;
            pend_reg    <= 1'b0;
            any_reg     <= 1'b0;
            caps_reg    <= 1'b0;
            tick_reg    <= 10'd0;
        end
        else if (proc)
        begin
            held_reg    <= held_next;
            running_reg <= running_next;
            link_reg    <= link_next;
            proto_reg   <= proto_next;
            lv_reg      <= lv_next;
            ladder_reg  <= ladder_next;
            count_reg   <= count_next;
            index_reg   <= index_next;
            target_reg  <= target_next;
            pend_reg    <= pend_next;
            any_reg     <= any_next;
            caps_reg    <= caps_next;
            tick_reg    <= tick_next;
        end
    end

    // a held contract is only released by reset
    assert property (@(posedge clk) disable iff (!rst_n) held_reg |=> held_reg)
        else $error("contract held flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.succeeded |-> out_item_reg.finished)
        else $error("success reported without finish");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.set_volt_strobe |-> out_item_reg.volt_request == 4'd0)
        else $error("voltage request without strobe");

    assert property (@(posedge clk) disable iff (!rst_n)
        proc && !running_reg && (in_item_reg.mode != pdvls_pkg::MODE_START)
        |=> $stable(index_reg) && $stable(tick_reg))
        else $error("idle poll changed sequencer state");

endmodule

// ----- sv/pdvls_ladder.sv -----
module pdvls_ladder #(
    parameter int LADDER_DEPTH = 4
) (
    input  logic [3:0]                    caps,
    output logic [LADDER_DEPTH-1:0][3:0]  ladder,
    output logic [2:0]                    count
);

    localparam logic [3:0] DEPTH_W = 4'(LADDER_DEPTH);

    always_comb
    begin
        ladder = '0;
        count  = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (caps[i] && ({1'b0, count} < DEPTH_W))
            begin
                for (int k = 0; k < LADDER_DEPTH; k++)
                begin
                    if (count == 3'(k))
                    begin
                        ladder[k] = pdvls_pkg::LADDER_VOLTS[i];
                    end
                end
                count = count + 3'd1;
            end
        end
    end

endmodule

// ----- sv/pdvls_judge.sv -----
module pdvls_judge (
    input  logic [1:0]  board,
    input  logic        any_ok,
    input  logic [4:0]  volt,
    input  logic [12:0] curr,
    input  logic [9:0]  freq_in,
    input  logic [9:0]  vcore_in,
    output logic        ok,
    output logic [9:0]  freq_out,
    output logic [9:0]  vcore_out
);

    logic pro;
    logic base;

    assign pro  = (board == pdvls_pkg::BOARD_PRO);
    assign base = (board == pdvls_pkg::BOARD_BASE);

    always_comb
    begin
        ok        = any_ok;
        freq_out  = freq_in;
        vcore_out = vcore_in;
        if (any_ok)
        begin
            if (volt == pdvls_pkg::VOLT_15)
            begin
                ok = (curr >= pdvls_pkg::CURR_15V_MIN);
            end
            else if (volt == pdvls_pkg::VOLT_12)
            begin
                ok = (curr >= pdvls_pkg::CURR_HIGH);
            end
            else if (volt == pdvls_pkg::VOLT_9)
            begin
                if (curr >= pdvls_pkg::CURR_HIGH)
                begin
                    if (pro)
                        freq_out = pdvls_pkg::clamp10(freq_in, pdvls_pkg::FREQ_PRO_HIGH);
                    else if (base)
                        freq_out = pdvls_pkg::clamp10(freq_in, pdvls_pkg::FREQ_BASE_HIGH);
                end
                else if (curr >= pdvls_pkg::CURR_MID)
                begin
                    if (pro)
                        freq_out = pdvls_pkg::clamp10(freq_in, pdvls_pkg::FREQ_PRO_MID);
                    else if (base)
                        freq_out = pdvls_pkg::clamp10(freq_in, pdvls_pkg::FREQ_BASE_MID);
                end
                else if (curr >= pdvls_pkg::CURR_LOW)
                begin
                    if (pro)
                        freq_out = pdvls_pkg::clamp10(freq_in, pdvls_pkg::FREQ_PRO_LOW);
                    else if (base)
                        freq_out = pdvls_pkg::clamp10(freq_in, pdvls_pkg::FREQ_BASE_LOW);
                end
                else
                begin
                    ok = 1'b0;
                end
                if (pro)
                    vcore_out = pdvls_pkg::clamp10(vcore_in, pdvls_pkg::VCORE_PRO_9V);
                else if (base)
                    vcore_out = pdvls_pkg::clamp10(vcore_in, pdvls_pkg::VCORE_BASE);
            end
            else
            begin
                if (curr < pdvls_pkg::CURR_HIGH)
                begin
                    ok = 1'b0;
                end
                else if (pro)
                begin
                    freq_out = pdvls_pkg::clamp10(freq_in, pdvls_pkg::FREQ_PRO_LOW);
                end
                else if (base)
                begin
                    freq_out = pdvls_pkg::clamp10(freq_in, pdvls_pkg::FREQ_BASE_OTH);
                end
                if (pro)
                    vcore_out = pdvls_pkg::clamp10(vcore_in, pdvls_pkg::VCORE_PRO_OTH);
                else if (base)
                    vcore_out = pdvls_pkg::clamp10(vcore_in, pdvls_pkg::VCORE_BASE);
            end
        end
    end

endmodule

// ----- dv/tb_pd_voltage_ladder_sequencer_unit.sv -----
module tb_pd_voltage_ladder_sequencer_unit;
    import pdvls_pkg::*;

    localparam int RUNGS = 4;
    localparam logic MODE_POLL = ~MODE_START;
    localparam logic [1:0] BOARD_OTHER = 2'd0;

    typedef enum int {RUN_NORMAL, RUN_STEP_TIMEOUT, RUN_GLOBAL_TIMEOUT} run_kind_t;
    typedef enum int {FLOW_FREE, FLOW_SPARSE, FLOW_PERIODIC, FLOW_HEAVY} flow_t;

    typedef struct {
        bit       held;
        bit       running;
        bit       link_up;
        bit       pending;
        bit       any_ok;
        bit       caps_loaded;
        bit [2:0] proto;
        bit [4:0] last_v;
        bit [3:0] rung [RUNGS];
        int       count;
        int       index;
        bit [3:0] target;
        int       ticks;
        bit [1:0] board;
        bit [9:0] freq;
        bit [9:0] vcore;
    } seq_state_t;

    class ladder_scoreboard;
        seq_state_t st;
        out_item_t  expected_results [$];
        int         errors;

        function new();
            st.held = 1'b0;
            st.running = 1'b0;
            st.board = BOARD_OTHER;
            st.freq = '0;
            st.vcore = '0;
            clear_work(st);
            errors = 0;
        endfunction

        function void clear_work(inout seq_state_t s);
            s.link_up = 1'b0;
            s.pending = 1'b0;
            s.any_ok = 1'b0;
            s.caps_loaded = 1'b0;
            s.proto = '0;
            s.last_v = '0;
            s.count = 0;
            s.index = 0;
            s.target = '0;
            s.ticks = 0;
            foreach (s.rung[i]) s.rung[i] = '0;
        endfunction

        function logic [3:0] rung_at(seq_state_t s, int i);
            return (i < RUNGS) ? s.rung[i] : 4'd0;
        endfunction

        function logic [9:0] derate(logic [9:0] v, logic [1:0] board,
                                    logic [9:0] pro_lim, logic [9:0] base_lim);
            if (board == BOARD_PRO && v > pro_lim) return pro_lim;
            if (board == BOARD_BASE && v > base_lim) return base_lim;
            return v;
        endfunction

        function bit contract_ok(inout seq_state_t s, input logic [12:0] ma);
            bit ok;
            if (!s.any_ok) return 1'b0;
            ok = 1'b1;
            if (s.last_v == VOLT_15) begin
                ok = (ma >= CURR_15V_MIN);
            end else if (s.last_v == VOLT_12) begin
                ok = (ma >= CURR_HIGH);
            end else if (s.last_v == VOLT_9) begin
                if (ma >= CURR_HIGH)
                    s.freq = derate(s.freq, s.board, FREQ_PRO_HIGH, FREQ_BASE_HIGH);
                else if (ma >= CURR_MID)
                    s.freq = derate(s.freq, s.board, FREQ_PRO_MID, FREQ_BASE_MID);
                else if (ma >= CURR_LOW)
                    s.freq = derate(s.freq, s.board, FREQ_PRO_LOW, FREQ_BASE_LOW);
                else
                    ok = 1'b0;
                s.vcore = derate(s.vcore, s.board, VCORE_PRO_9V, VCORE_BASE);
            end else begin
                if (ma >= CURR_HIGH)
                    s.freq = derate(s.freq, s.board, FREQ_PRO_LOW, FREQ_BASE_OTH);
                else
                    ok = 1'b0;
                s.vcore = derate(s.vcore, s.board, VCORE_PRO_OTH, VCORE_BASE);
            end
            return ok;
        endfunction

        function out_item_t advance(inout seq_state_t s, input in_item_t it);
            out_item_t  r;
            logic [3:0] caps;
            bit         done;
            bit         skip_tail;
            int         next_ticks;
            r = '0;
            done = 1'b0;
            skip_tail = 1'b0;
            caps = {it.cap_15v, it.cap_12v, it.cap_9v, it.cap_5v};
            if (it.mode == MODE_START) begin
                if (s.held) begin
                    r.finished = 1'b1;
                    r.succeeded = 1'b1;
                end else begin
                    clear_work(s);
                    s.running = 1'b1;
                end
            end else if (s.running) begin
                if (!s.link_up) begin
                    s.link_up = it.attached && it.sink_ready;
                end else begin
                    if (s.proto == '0) s.proto = it.protocol_code;
                    s.last_v = it.measured_volt;
                end
                if (s.link_up && s.proto != '0) begin
                    if (!s.caps_loaded) begin
                        s.count = 0;
                        for (int i = 0; i < 4; i++) begin
                            if (caps[i] && s.count < RUNGS) begin
                                s.rung[s.count] = LADDER_VOLTS[i];
                                s.count++;
                            end
                        end
                        if (s.count == 0) begin
                            done = 1'b1;
                        end else begin
                            s.target = rung_at(s, s.index);
                            s.caps_loaded = 1'b1;
                        end
                    end
                    if (!done && s.last_v == s.target) begin
                        s.any_ok = 1'b1;
                        if (s.index + 1 >= s.count) begin
                            done = 1'b1;
                        end else begin
                            s.index++;
                            s.target = rung_at(s, s.index);
                            s.ticks = 0;
                            s.pending = 1'b0;
                            r.gate_open_strobe = 1'b1;
                            skip_tail = 1'b1;
                        end
                    end
                    if (!done && !skip_tail) begin
                        if (s.last_v != '0 && !s.pending && s.target != '0) begin
                            r.set_volt_strobe = 1'b1;
                            r.volt_request = s.target;
                            s.pending = 1'b1;
                            s.ticks = 0;
                        end
                        if (s.ticks > STEP_TIMEOUT) begin
                            s.index++;
                            if (s.index >= s.count) begin
                                done = 1'b1;
                            end else begin
                                s.target = rung_at(s, s.index);
                                s.pending = 1'b0;
                                s.ticks = 0;
                            end
                        end
                    end
                end
                // saturating count, but the timeout sees the raw increment
                if (!done && !skip_tail) begin
                    next_ticks = s.ticks + 1;
                    s.ticks = (next_ticks > TICK_MAX) ? int'(TICK_MAX) : next_ticks;
                    if (next_ticks > GLOBAL_TIMEOUT) done = 1'b1;
                end
                if (done) begin
                    r.finished = 1'b1;
                    s.running = 1'b0;
                    r.succeeded = contract_ok(s, it.contract_current_ma);
                    if (r.succeeded) begin
                        r.gate_open_strobe = 1'b1;
                        s.held = 1'b1;
                    end
                end
            end
            r.freq_limit = s.freq;
            r.core_volt_limit = s.vcore;
            return r;
        endfunction

        function void write_reg(logic [1:0] idx, logic [9:0] val);
            case (idx)
                CFG_BOARD_MODEL: st.board = val[1:0];
                CFG_FREQ_LIMIT:  st.freq = val;
                CFG_CORE_VOLT:   st.vcore = val;
                default: ;
            endcase
        endfunction

        function void note_input(in_item_t it);
            expected_results.push_back(advance(st, it));
        endfunction

        function bit would_succeed(in_item_t it);
            seq_state_t s;
            out_item_t  r;
            s = st;
            r = advance(s, it);
            return r.succeeded;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [12:0] got, logic [12:0] want);
            if (got !== want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0) begin
                report("result transfer with nothing pending");
                return;
            end
            want = expected_results.pop_front();
            compare_field("finished", got.finished, want.finished);
            compare_field("succeeded", got.succeeded, want.succeeded);
            compare_field("set_volt_strobe", got.set_volt_strobe, want.set_volt_strobe);
            compare_field("volt_request", got.volt_request, want.volt_request);
            compare_field("gate_open_strobe", got.gate_open_strobe, want.gate_open_strobe);
            compare_field("freq_limit", got.freq_limit, want.freq_limit);
            compare_field("core_volt_limit", got.core_volt_limit, want.core_volt_limit);
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_item;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_BOARD_MODEL;
    logic [9:0] cfg_data = '0;

    ladder_scoreboard sb = new();
    bit    allow_win = 1'b0;
    int    burst_left = 0;
    int    stall_tick = 0;
    flow_t flow = FLOW_FREE;

    pd_voltage_ladder_sequencer_unit #(
        .LADDER_DEPTH(RUNGS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_tick % 200 == 0) flow = flow_t'($urandom_range(0, 3));
        stall_tick++;
        case (flow)
            FLOW_FREE:     out_stall <= 1'b0;
            FLOW_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
            FLOW_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
            default:       out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    end

    function automatic in_item_t make_item(logic m, logic att, logic rdy, logic [2:0] pc,
                                           logic [4:0] mv, logic [3:0] caps,
                                           logic [12:0] ma);
        in_item_t it;
        it.mode = m;
        it.attached = att;
        it.sink_ready = rdy;
        it.protocol_code = pc;
        it.measured_volt = mv;
        {it.cap_15v, it.cap_12v, it.cap_9v, it.cap_5v} = caps;
        it.contract_current_ma = ma;
        return it;
    endfunction

    function automatic in_item_t random_item();
        logic [31:0] r;
        r = $urandom;
        return in_item_t'(r[$bits(in_item_t)-1:0]);
    endfunction

    // one input transfer; bursts with random gaps between them
    task automatic feed(in_item_t it);
        if (!allow_win && sb.would_succeed(it))
            it.contract_current_ma = $urandom_range(0, CURR_15V_MIN - 1);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic reconfigure(logic [1:0] board, logic [9:0] freq, logic [9:0] vcore);
        logic [9:0] vals [3];
        vals[CFG_BOARD_MODEL] = {8'd0, board};
        vals[CFG_FREQ_LIMIT] = freq;
        vals[CFG_CORE_VOLT] = vcore;
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.expected_results.size() != 0);
        for (int idx = CFG_BOARD_MODEL; idx <= CFG_CORE_VOLT; idx++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[1:0];
            cfg_data <= vals[idx];
            @(negedge clk);
            sb.write_reg(idx[1:0], vals[idx]);
        end
        cfg_we <= 1'b0;
        burst_left = 0;
    endtask

    task automatic negotiate(run_kind_t kind);
        in_item_t   it;
        int         polls;
        int         restart_at;
        bit         starve_link;
        logic [3:0] one_cap;
        starve_link = $urandom_range(0, 1);
        restart_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 8)) : -1;
        one_cap = 4'b0001 << $urandom_range(0, 3);
        it = random_item();
        it.mode = MODE_START;
        feed(it);
        polls = 0;
        while (sb.st.running && polls < 1200) begin
            it = random_item();
            it.mode = (kind == RUN_NORMAL && polls == restart_at) ? MODE_START : MODE_POLL;
            if (!sb.st.link_up) begin
                if (kind == RUN_GLOBAL_TIMEOUT && starve_link) begin
                    if (it.attached) it.sink_ready = 1'b0;
                end else if ($urandom_range(0, 2) != 0) begin
                    it.attached = 1'b1;
                    it.sink_ready = 1'b1;
                end
            end else if (sb.st.proto == '0) begin
                if (kind == RUN_GLOBAL_TIMEOUT)
                    it.protocol_code = '0;
                else if ($urandom_range(0, 3) != 0)
                    it.protocol_code = $urandom_range(1, 7);
            end
            if (kind == RUN_STEP_TIMEOUT) begin
                {it.cap_15v, it.cap_12v, it.cap_9v, it.cap_5v} = one_cap;
                // above every rung, so no step ever matches
                it.measured_volt = $urandom_range(16, 31);
            end else if (sb.st.caps_loaded) begin
                case ($urandom_range(0, 19))
                    12, 13, 14:    it.measured_volt = '0;
                    15, 16, 17, 18, 19: ;
                    default:       it.measured_volt = sb.st.target;
                endcase
            end else if ($urandom_range(0, 2) == 0) begin
                it.measured_volt = LADDER_VOLTS[$urandom_range(0, 3)];
            end
            polls++;
            feed(it);
        end
    endtask

    task automatic close_contract();
        in_item_t it;
        it = random_item();
        it.mode = MODE_START;
        feed(it);
        while (sb.st.running) begin
            it = random_item();
            it.mode = MODE_POLL;
            it.attached = 1'b1;
            it.sink_ready = 1'b1;
            if (it.protocol_code == '0) it.protocol_code = 3'd1;
            if ({it.cap_15v, it.cap_12v, it.cap_9v, it.cap_5v} == '0) it.cap_5v = 1'b1;
            if (sb.st.caps_loaded) it.measured_volt = sb.st.target;
            it.contract_current_ma = $urandom_range(CURR_HIGH, 8191);
            feed(it);
        end
    endtask

    initial
    begin
        run_kind_t kind;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        reconfigure(BOARD_PRO, 10'd1023, 10'd1023);

        feed(make_item(MODE_POLL, 1, 1, 3'd7, 5'd31, 4'b1111, 13'd8191));
        feed(make_item(MODE_POLL, 0, 0, 3'd0, 5'd0, 4'b0000, 13'd0));
        feed(make_item(MODE_START, 0, 0, 3'd0, 5'd0, 4'b0000, 13'd0));
        feed(make_item(MODE_POLL, 1, 0, 3'd0, 5'd0, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 0, 1, 3'd0, 5'd0, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd0, 5'd0, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd3, 5'd0, 4'b0000, 13'd0));
        feed(make_item(MODE_START, 1, 1, 3'd0, 5'd0, 4'b0000, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd0, 5'd7, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd0, 5'd7, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd5, 5'd0, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd2, 5'd4, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd2, 5'd5, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd2, 5'd9, 4'b1111, 13'd0));
        feed(make_item(MODE_START, 1, 1, 3'd2, 5'd9, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd0, 5'd0, 4'b1111, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd1, 5'd9, 4'b0010, 13'd1000));
        feed(make_item(MODE_START, 0, 0, 3'd0, 5'd0, 4'b0000, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd0, 5'd0, 4'b0000, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd2, 5'd12, 4'b1100, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd2, 5'd15, 4'b1100, 13'd1999));
        feed(make_item(MODE_START, 0, 0, 3'd0, 5'd0, 4'b0000, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd0, 5'd0, 4'b0000, 13'd0));
        feed(make_item(MODE_POLL, 1, 1, 3'd6, 5'd5, 4'b0001, 13'd2999));

        for (int n = 0; n < 60; n++) begin
            case (n)
                12: reconfigure(BOARD_OTHER, 10'd0, 10'd1023);
                24: reconfigure(BOARD_BASE, 10'd1023, $urandom_range(0, 1023));
                36: reconfigure(BOARD_PRO, $urandom_range(0, 1023), 10'd0);
                48: reconfigure($urandom_range(0, 2), $urandom_range(0, 1023),
                                $urandom_range(0, 1023));
                default: ;
            endcase
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 6)) feed(random_item());
            if (n == 5)
                kind = RUN_GLOBAL_TIMEOUT;
            else if (n == 17 || n == 40)
                kind = RUN_STEP_TIMEOUT;
            else
                kind = RUN_NORMAL;
            negotiate(kind);
        end

        reconfigure($urandom_range(0, 2), $urandom_range(0, 1023), $urandom_range(0, 1023));
        allow_win = 1'b1;
        close_contract();
        repeat (10) feed(random_item());

        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_pd_voltage_ladder_sequencer_unit: PASS");
        else
            $display("tb_pd_voltage_ladder_sequencer_unit: FAIL");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_pd_voltage_ladder_sequencer_unit: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/pdvls_pkg.sv
sv/pdvls_ladder.sv
sv/pdvls_judge.sv
sv/pd_voltage_ladder_sequencer_unit.sv
dv/tb_pd_voltage_ladder_sequencer_unit.sv
